FILE: rtl/rsb_pkg.sv
// Shared types, codes and helper functions of the restart supervisor.
package rsb_pkg;

	// Timestamp width and the all-ones value that deadlines saturate at.
	localparam int TIME_BITS = 48;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	// Backoff schedule size and the cap on the schedule length in use.
	localparam int NUM_DELAYS = 4;
	localparam int MAX_SCHEDULE = 4;
	localparam int DLY_IDX_W = $clog2(NUM_DELAYS);
	localparam logic [2:0] SCHED_CAP =
		3'((MAX_SCHEDULE < NUM_DELAYS) ? MAX_SCHEDULE : NUM_DELAYS);

	// Attempt counter saturation value.
	localparam logic [2:0] ATTEMPT_MAX = 3'd7;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_ARM_WAIT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_FAIL = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_WINDOW = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCHED_LEN = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_DELAY_0 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_DELAY_1 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_DELAY_2 = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_DELAY_3 = 4'd7;

	// Event kinds.
	typedef enum logic [1:0] {
		FUNC_TICK    = 2'd0,
		FUNC_SPAWNED = 2'd1,
		FUNC_EXITED  = 2'd2
	} func_t;

	// Supervisor modes.
	typedef enum logic [2:0] {
		MODE_IDLE     = 3'd0,
		MODE_ARMED    = 3'd1,
		MODE_STARTING = 3'd2,
		MODE_RUNNING  = 3'd3,
		MODE_BACKOFF  = 3'd4,
		MODE_LOCKED   = 3'd5
	} mode_t;

	// One input item.
	typedef struct packed {
		logic [1:0]           func;
		logic                 arm_left;
		logic                 arm_right;
		logic                 start_button;
		logic                 link_up;
		logic [47:0]          now_time;
		logic signed [31:0]   worker_id;
		logic signed [31:0]   exit_status;
		logic [31:0]          run_time;
	} item_t;

	// One result item.
	typedef struct packed {
		logic                 start_worker;
		logic                 stop_worker;
		logic [2:0]           mode;
		logic [2:0]           attempt_count;
		logic [31:0]          active_backoff;
		logic signed [31:0]   current_worker;
	} result_t;

	// Configuration register contents.
	typedef struct packed {
		logic [31:0]                  arm_wait;
		logic [31:0]                  fast_fail_threshold;
		logic [31:0]                  fail_span;
		logic [2:0]                   schedule_length;
		logic [NUM_DELAYS-1:0][31:0]  backoff_delay;
	} cfg_t;

	// Add a delay to a timestamp, saturating at the largest timestamp.
	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
			input logic [31:0] d);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, t} + (TIME_BITS+1)'(d);
		return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
	endfunction

endpackage

FILE: rtl/restart_supervisor_with_backoff_top.sv
// Top level of the restart supervisor: input register, core, result register.
//
// The supervisor takes one event item per clock cycle while its results are
// taken and returns exactly one result item for each, in order. An accepted
// item sits in the input register while the core computes the next state and
// result, and the result register loads that result once it is empty or being
// taken. The throughput of one item per cycle is set by the single pass through
// the core's next-state logic, whose longest path runs from the failure-window
// compare through the attempt count and delay select into a 48-bit saturating
// deadline add. When the result register is full and not taken, the input
// register holds its item and item_ready drops.
// Configuration writes are always ready and should only be issued while no
// item is in flight.
module restart_supervisor_with_backoff_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  rsb_pkg::item_t                       item,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output rsb_pkg::result_t                     result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rsb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [31:0]                          cfg_data
);

	rsb_pkg::item_t    item_s1;
	logic              item_valid_s1;
	rsb_pkg::result_t  result_s2;
	logic              result_valid_s2;
	rsb_pkg::result_t  core_result;
	rsb_pkg::cfg_t     cfg;
	logic              advance;

	assign cfg_ready = 1'b1;

	// The core consumes the held item when the result register can take it.
	assign advance = item_valid_s1 && (!result_valid_s2 || result_ready);
	assign item_ready = !item_valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= 1'b1;
		end else if (result_ready) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= core_result;
		end
	end

	assign result_valid = result_valid_s2;
	assign result = result_s2;

	rsb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rsb_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (core_result)
	);

endmodule

FILE: rtl/rsb_cfg.sv
// Configuration register file of the restart supervisor.
module rsb_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [rsb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [31:0]                          cfg_data,
	output rsb_pkg::cfg_t                        cfg
);

	rsb_pkg::cfg_t cfg_q;

	// Registers load on a completed write; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arm_wait <= 32'd5000;
			cfg_q.fast_fail_threshold <= 32'd10000;
			cfg_q.fail_span <= 32'd60000;
			cfg_q.schedule_length <= 3'd4;
			cfg_q.backoff_delay[0] <= 32'd1000;
			cfg_q.backoff_delay[1] <= 32'd2000;
			cfg_q.backoff_delay[2] <= 32'd4000;
			cfg_q.backoff_delay[3] <= 32'd8000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rsb_pkg::CFG_ARM_WAIT:        cfg_q.arm_wait <= cfg_data;
				rsb_pkg::CFG_FAST_FAIL:       cfg_q.fast_fail_threshold <= cfg_data;
				rsb_pkg::CFG_FAIL_WINDOW:     cfg_q.fail_span <= cfg_data;
				rsb_pkg::CFG_SCHED_LEN:       cfg_q.schedule_length <= cfg_data[2:0];
				rsb_pkg::CFG_BACKOFF_DELAY_0: cfg_q.backoff_delay[0] <= cfg_data;
				rsb_pkg::CFG_BACKOFF_DELAY_1: cfg_q.backoff_delay[1] <= cfg_data;
				rsb_pkg::CFG_BACKOFF_DELAY_2: cfg_q.backoff_delay[2] <= cfg_data;
				rsb_pkg::CFG_BACKOFF_DELAY_3: cfg_q.backoff_delay[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/rsb_core.sv
// Supervisor state registers and the per-item next-state logic.
module rsb_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  rsb_pkg::item_t    item,
	input  rsb_pkg::cfg_t     cfg,
	output rsb_pkg::result_t  result
);

	localparam int TB = rsb_pkg::TIME_BITS;

	// Supervisor state.
	rsb_pkg::mode_t      mode_q, mode_d;
	logic                prev_combo_q, prev_combo_d;
	logic                prev_start_q, prev_start_d;
	logic signed [31:0]  worker_q, worker_d;
	logic [2:0]          attempt_q, attempt_d;
	logic [31:0]         backoff_q, backoff_d;
	logic [TB-1:0]       arm_dl_q, arm_dl_d;
	logic [TB-1:0]       restart_dl_q, restart_dl_d;
	logic [TB-1:0]       win_start_q, win_start_d;
	logic                win_valid_q, win_valid_d;

	// Decoded item terms.
	logic                    combo, arm_rise, start_rise, no_worker;
	logic [TB-1:0]           now;
	logic [TB-1:0]           win_age;
	logic                    new_window;
	logic [2:0]              sched_len;
	logic [2:0]              att_base, att_new;
	logic [2:0]              att_minus1;
	logic [rsb_pkg::DLY_IDX_W-1:0] dly_idx;
	logic [31:0]             dly_sel;
	logic                    start_o, stop_o;

	// Edge detection, window age and the attempt count an exit would produce.
	always_comb begin
		combo = item.arm_left && item.arm_right;
		arm_rise = combo && !prev_combo_q;
		start_rise = item.start_button && !prev_start_q;
		no_worker = (worker_q <= 32'sd0);
		now = TB'(item.now_time);
		win_age = now - win_start_q;
		new_window = (item.run_time >= cfg.fast_fail_threshold) || !win_valid_q ||
			(win_age > TB'(cfg.fail_span));
		sched_len = (cfg.schedule_length > rsb_pkg::SCHED_CAP) ?
			rsb_pkg::SCHED_CAP : cfg.schedule_length;
		att_base = new_window ? 3'd0 : attempt_q;
		att_new = (att_base < rsb_pkg::ATTEMPT_MAX) ?
			att_base + 3'd1 : rsb_pkg::ATTEMPT_MAX;
		att_minus1 = att_new - 3'd1;
		dly_idx = att_minus1[rsb_pkg::DLY_IDX_W-1:0];
		dly_sel = cfg.backoff_delay[dly_idx];
	end

	// Next state for the item in the input register.
	always_comb begin
		mode_d = mode_q;
		prev_combo_d = prev_combo_q;
		prev_start_d = prev_start_q;
		worker_d = worker_q;
		attempt_d = attempt_q;
		backoff_d = backoff_q;
		arm_dl_d = arm_dl_q;
		restart_dl_d = restart_dl_q;
		win_start_d = win_start_q;
		win_valid_d = win_valid_q;
		start_o = 1'b0;
		stop_o = 1'b0;
		case (rsb_pkg::func_t'(item.func))
			rsb_pkg::FUNC_TICK: begin
				prev_combo_d = combo;
				prev_start_d = item.start_button;
				case (mode_q)
					rsb_pkg::MODE_IDLE: begin
						if (item.link_up && arm_rise && no_worker) begin
							mode_d = rsb_pkg::MODE_ARMED;
							arm_dl_d = rsb_pkg::sat_add(now, cfg.arm_wait);
						end
					end
					rsb_pkg::MODE_ARMED: begin
						if (!item.link_up || now >= arm_dl_q) begin
							mode_d = rsb_pkg::MODE_IDLE;
						end else if (start_rise) begin
							mode_d = rsb_pkg::MODE_STARTING;
							start_o = 1'b1;
						end
					end
					rsb_pkg::MODE_STARTING: begin
						if (!item.link_up) begin
							mode_d = rsb_pkg::MODE_IDLE;
							stop_o = 1'b1;
						end
					end
					rsb_pkg::MODE_RUNNING: begin
						if (!item.link_up) begin
							mode_d = rsb_pkg::MODE_IDLE;
							stop_o = 1'b1;
							attempt_d = 3'd0;
							backoff_d = 32'd0;
							arm_dl_d = '0;
							restart_dl_d = '0;
							win_start_d = '0;
							win_valid_d = 1'b0;
						end
					end
					rsb_pkg::MODE_BACKOFF: begin
						if (!item.link_up) begin
							mode_d = rsb_pkg::MODE_IDLE;
							attempt_d = 3'd0;
							backoff_d = 32'd0;
							arm_dl_d = '0;
							restart_dl_d = '0;
							win_start_d = '0;
							win_valid_d = 1'b0;
						end else if (now >= restart_dl_q) begin
							mode_d = rsb_pkg::MODE_STARTING;
							start_o = 1'b1;
						end
					end
					default: begin
						// Locked: a fresh arm combination clears the budget and arms.
						if (item.link_up && arm_rise && no_worker) begin
							attempt_d = 3'd0;
							backoff_d = 32'd0;
							restart_dl_d = '0;
							win_start_d = '0;
							win_valid_d = 1'b0;
							mode_d = rsb_pkg::MODE_ARMED;
							arm_dl_d = rsb_pkg::sat_add(now, cfg.arm_wait);
						end
					end
				endcase
			end
			rsb_pkg::FUNC_SPAWNED: begin
				worker_d = item.worker_id;
				mode_d = rsb_pkg::MODE_RUNNING;
			end
			rsb_pkg::FUNC_EXITED: begin
				worker_d = -32'sd1;
				backoff_d = 32'd0;
				restart_dl_d = '0;
				if (item.exit_status == 32'sd0 || !item.link_up) begin
					mode_d = rsb_pkg::MODE_IDLE;
					attempt_d = 3'd0;
					arm_dl_d = '0;
					win_start_d = '0;
					win_valid_d = 1'b0;
				end else begin
					if (new_window) begin
						win_start_d = now;
						win_valid_d = 1'b1;
					end
					attempt_d = att_new;
					if (att_new > sched_len) begin
						mode_d = rsb_pkg::MODE_LOCKED;
					end else begin
						backoff_d = dly_sel;
						restart_dl_d = rsb_pkg::sat_add(now, dly_sel);
						mode_d = rsb_pkg::MODE_BACKOFF;
					end
				end
			end
			default: ;
		endcase
	end

	// The result shows the state after the item.
	always_comb begin
		result.start_worker = start_o;
		result.stop_worker = stop_o;
		result.mode = mode_d;
		result.attempt_count = attempt_d;
		result.active_backoff = backoff_d;
		result.current_worker = worker_d;
	end

	// State update, once per item taken from the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rsb_pkg::MODE_IDLE;
			prev_combo_q <= 1'b0;
			prev_start_q <= 1'b0;
			worker_q <= -32'sd1;
			attempt_q <= 3'd0;
			backoff_q <= 32'd0;
			arm_dl_q <= '0;
			restart_dl_q <= '0;
			win_start_q <= '0;
			win_valid_q <= 1'b0;
		end else if (advance) begin
			mode_q <= mode_d;
			prev_combo_q <= prev_combo_d;
			prev_start_q <= prev_start_d;
			worker_q <= worker_d;
			attempt_q <= attempt_d;
			backoff_q <= backoff_d;
			arm_dl_q <= arm_dl_d;
			restart_dl_q <= restart_dl_d;
			win_start_q <= win_start_d;
			win_valid_q <= win_valid_d;
		end
	end

endmodule

FILE: tb/restart_supervisor_with_backoff_top_tb.sv
// Testbench of the restart supervisor: directed and random events checked by a predictor.
`timescale 1ns / 1ps

module restart_supervisor_with_backoff_top_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS = 10;
	localparam logic signed [31:0] NO_WORKER = -32'sd1;
	localparam int TW = rsb_pkg::TIME_BITS;
	localparam int IDX_W = rsb_pkg::CFG_IDX_W;
	localparam int SEL_W = rsb_pkg::DLY_IDX_W;
	localparam int NDLY = rsb_pkg::NUM_DELAYS;

	// Register settings that the random phases run under.
	typedef enum int {SET_MODERATE, SET_LOW, SET_HIGH, SET_WILD} setting_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	rsb_pkg::item_t item;
	logic result_valid;
	logic result_ready;
	rsb_pkg::result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	int tx_idle_pct;
	int rx_idle_pct;
	int fail_count;
	int cycle_count;
	rsb_pkg::result_t expected_results[$];

	// Shadow copy of the configuration registers.
	logic [31:0] cfg_arm_wait;
	logic [31:0] cfg_fast_fail;
	logic [31:0] cfg_window;
	logic [2:0] cfg_sched_len;
	logic [31:0] cfg_delay [NDLY];

	// Predicted supervisor state.
	rsb_pkg::mode_t sup_mode;
	logic combo_seen;
	logic start_seen;
	logic signed [31:0] worker_seen;
	logic [2:0] attempts;
	logic [31:0] pending_backoff;
	logic [TW-1:0] arm_deadline_q;
	logic [TW-1:0] restart_deadline_q;
	logic [TW-1:0] window_start_q;
	logic window_open;

	// Running timestamp of the random event streams.
	logic [TW-1:0] clock_now;

	restart_supervisor_with_backoff_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Deadline arithmetic: clamp at the largest timestamp instead of wrapping.
	function automatic logic [TW-1:0] deadline_after(input logic [TW-1:0] t,
			input logic [31:0] d);
		if (TW'(d) > rsb_pkg::TIME_MAX - t)
			return rsb_pkg::TIME_MAX;
		return t + TW'(d);
	endfunction

	function automatic void forget_failures();
		attempts = '0;
		pending_backoff = '0;
		arm_deadline_q = '0;
		restart_deadline_q = '0;
		window_start_q = '0;
		window_open = 1'b0;
	endfunction

	function automatic void arm_at(input logic [TW-1:0] now);
		sup_mode = rsb_pkg::MODE_ARMED;
		arm_deadline_q = deadline_after(now, cfg_arm_wait);
	endfunction

	task automatic reset_prediction();
		cfg_arm_wait = 32'd5000;
		cfg_fast_fail = 32'd10000;
		cfg_window = 32'd60000;
		cfg_sched_len = 3'd4;
		cfg_delay[0] = 32'd1000;
		cfg_delay[1] = 32'd2000;
		cfg_delay[2] = 32'd4000;
		cfg_delay[3] = 32'd8000;
		sup_mode = rsb_pkg::MODE_IDLE;
		combo_seen = 1'b0;
		start_seen = 1'b0;
		worker_seen = NO_WORKER;
		forget_failures();
		clock_now = '0;
	endtask

	// Next state and result of the supervisor for one event.
	function automatic rsb_pkg::result_t supervise(input rsb_pkg::item_t ev);
		rsb_pkg::result_t r;
		logic combo;
		logic arm_rise;
		logic start_rise;
		logic [2:0] usable;
		logic [TW-1:0] age;
		r = '0;
		combo = ev.arm_left & ev.arm_right;
		arm_rise = combo & ~combo_seen;
		start_rise = ev.start_button & ~start_seen;
		case (ev.func)
			rsb_pkg::FUNC_TICK: begin
				case (sup_mode)
					rsb_pkg::MODE_IDLE: begin
						if (ev.link_up && arm_rise && worker_seen <= 0)
							arm_at(ev.now_time);
					end
					rsb_pkg::MODE_ARMED: begin
						if (!ev.link_up || ev.now_time >= arm_deadline_q) begin
							sup_mode = rsb_pkg::MODE_IDLE;
						end else if (start_rise) begin
							sup_mode = rsb_pkg::MODE_STARTING;
							r.start_worker = 1'b1;
						end
					end
					rsb_pkg::MODE_STARTING: begin
						if (!ev.link_up) begin
							sup_mode = rsb_pkg::MODE_IDLE;
							r.stop_worker = 1'b1;
						end
					end
					rsb_pkg::MODE_RUNNING: begin
						if (!ev.link_up) begin
							sup_mode = rsb_pkg::MODE_IDLE;
							r.stop_worker = 1'b1;
							forget_failures();
						end
					end
					rsb_pkg::MODE_BACKOFF: begin
						if (!ev.link_up) begin
							sup_mode = rsb_pkg::MODE_IDLE;
							forget_failures();
						end else if (ev.now_time >= restart_deadline_q) begin
							sup_mode = rsb_pkg::MODE_STARTING;
							r.start_worker = 1'b1;
						end
					end
					default: begin
						// Locked: only a fresh arm combination gets out.
						if (ev.link_up && arm_rise && worker_seen <= 0) begin
							forget_failures();
							arm_at(ev.now_time);
						end
					end
				endcase
				combo_seen = combo;
				start_seen = ev.start_button;
			end
			rsb_pkg::FUNC_SPAWNED: begin
				worker_seen = ev.worker_id;
				sup_mode = rsb_pkg::MODE_RUNNING;
			end
			rsb_pkg::FUNC_EXITED: begin
				worker_seen = NO_WORKER;
				pending_backoff = '0;
				restart_deadline_q = '0;
				if (ev.exit_status == 0 || !ev.link_up) begin
					sup_mode = rsb_pkg::MODE_IDLE;
					forget_failures();
				end else begin
					usable = (cfg_sched_len > rsb_pkg::SCHED_CAP) ?
						rsb_pkg::SCHED_CAP : cfg_sched_len;
					age = ev.now_time - window_start_q;
					// A slow failure or a stale window starts a new failure count.
					if (ev.run_time >= cfg_fast_fail || !window_open ||
							age > TW'(cfg_window)) begin
						window_start_q = ev.now_time;
						window_open = 1'b1;
						attempts = '0;
					end
					if (attempts < rsb_pkg::ATTEMPT_MAX)
						attempts = attempts + 3'd1;
					if (attempts > usable) begin
						sup_mode = rsb_pkg::MODE_LOCKED;
					end else begin
						pending_backoff = cfg_delay[SEL_W'(attempts - 3'd1)];
						restart_deadline_q = deadline_after(ev.now_time, pending_backoff);
						sup_mode = rsb_pkg::MODE_BACKOFF;
					end
				end
			end
			default: ;
		endcase
		r.mode = sup_mode;
		r.attempt_count = attempts;
		r.active_backoff = pending_backoff;
		r.current_worker = worker_seen;
		return r;
	endfunction

	// Event builders: unused fields carry random bits.
	function automatic rsb_pkg::item_t random_item();
		rsb_pkg::item_t ev;
		ev.func = 2'($urandom);
		ev.arm_left = 1'($urandom);
		ev.arm_right = 1'($urandom);
		ev.start_button = 1'($urandom);
		ev.link_up = 1'($urandom);
		ev.now_time = {16'($urandom), 32'($urandom)};
		ev.worker_id = $urandom;
		ev.exit_status = $urandom;
		ev.run_time = $urandom;
		return ev;
	endfunction

	function automatic rsb_pkg::item_t tick_at(input logic l, input logic r, input logic s,
			input logic link, input logic [TW-1:0] now);
		rsb_pkg::item_t ev;
		ev = random_item();
		ev.func = rsb_pkg::FUNC_TICK;
		ev.arm_left = l;
		ev.arm_right = r;
		ev.start_button = s;
		ev.link_up = link;
		ev.now_time = now;
		return ev;
	endfunction

	function automatic rsb_pkg::item_t spawned(input logic signed [31:0] pid);
		rsb_pkg::item_t ev;
		ev = random_item();
		ev.func = rsb_pkg::FUNC_SPAWNED;
		ev.worker_id = pid;
		return ev;
	endfunction

	function automatic rsb_pkg::item_t exited(input logic signed [31:0] code,
			input logic [31:0] runtime, input logic link, input logic [TW-1:0] now);
		rsb_pkg::item_t ev;
		ev = random_item();
		ev.func = rsb_pkg::FUNC_EXITED;
		ev.exit_status = code;
		ev.run_time = runtime;
		ev.link_up = link;
		ev.now_time = now;
		return ev;
	endfunction

	// Pick an event that moves the predicted supervisor along its lifecycle.
	function automatic rsb_pkg::item_t next_lifecycle_event();
		rsb_pkg::item_t ev;
		logic want_combo;
		ev = random_item();
		if ($urandom_range(0, 99) < 8)
			return ev;
		if ($urandom_range(0, 199) == 0)
			clock_now = rsb_pkg::TIME_MAX - TW'($urandom_range(0, 20000));
		else
			clock_now = clock_now + TW'($urandom_range(0, 1500));
		ev.now_time = clock_now;
		ev.link_up = ($urandom_range(0, 99) >= 3);
		ev.func = rsb_pkg::FUNC_TICK;
		case (sup_mode)
			rsb_pkg::MODE_ARMED: begin
				ev.start_button = start_seen ? ($urandom_range(0, 99) < 30)
					: ($urandom_range(0, 99) < 70);
				if ($urandom_range(0, 19) == 0)
					ev.now_time = arm_deadline_q;
			end
			rsb_pkg::MODE_STARTING: begin
				if ($urandom_range(0, 99) < 85)
					ev.func = rsb_pkg::FUNC_SPAWNED;
			end
			rsb_pkg::MODE_RUNNING: begin
				if ($urandom_range(0, 99) < 70)
					ev.func = rsb_pkg::FUNC_EXITED;
			end
			rsb_pkg::MODE_BACKOFF: begin
				case ($urandom_range(0, 9))
					0: ev.func = rsb_pkg::FUNC_SPAWNED;
					1: ev.func = rsb_pkg::FUNC_EXITED;
					2, 3, 4, 5: begin
						clock_now = restart_deadline_q;
						ev.now_time = clock_now;
					end
					default: ;
				endcase
			end
			default: begin
				if (worker_seen > 0 && $urandom_range(0, 99) < 30) begin
					ev.func = rsb_pkg::FUNC_EXITED;
				end else begin
					want_combo = ($urandom_range(0, 99) < 70) ? ~combo_seen : combo_seen;
					ev.arm_left = want_combo | 1'($urandom);
					ev.arm_right = want_combo | (~ev.arm_left & 1'($urandom));
				end
			end
		endcase
		// Shape the fields that matter for spawn and exit reports.
		if (ev.func == rsb_pkg::FUNC_SPAWNED && $urandom_range(0, 19) == 0)
			ev.worker_id = '0;
		if (ev.func == rsb_pkg::FUNC_EXITED) begin
			ev.link_up = ($urandom_range(0, 99) >= 5);
			if ($urandom_range(0, 99) < 15)
				ev.exit_status = '0;
			if ($urandom_range(0, 99) < 60)
				ev.run_time = $urandom_range(0, cfg_fast_fail);
		end
		return ev;
	endfunction

	// Send one item on the event channel and record what it should produce.
	task automatic send_event(input rsb_pkg::item_t ev);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= ev;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		expected_results.push_back(supervise(ev));
	endtask

	// Write one register; cfg_valid is lowered by the caller after the last write.
	task automatic write_reg(input logic [IDX_W-1:0] index, input logic [31:0] data);
		cfg_index <= index;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			rsb_pkg::CFG_ARM_WAIT: cfg_arm_wait = data;
			rsb_pkg::CFG_FAST_FAIL: cfg_fast_fail = data;
			rsb_pkg::CFG_FAIL_WINDOW: cfg_window = data;
			rsb_pkg::CFG_SCHED_LEN: cfg_sched_len = data[2:0];
			rsb_pkg::CFG_BACKOFF_DELAY_0: cfg_delay[0] = data;
			rsb_pkg::CFG_BACKOFF_DELAY_1: cfg_delay[1] = data;
			rsb_pkg::CFG_BACKOFF_DELAY_2: cfg_delay[2] = data;
			rsb_pkg::CFG_BACKOFF_DELAY_3: cfg_delay[3] = data;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input setting_t s);
		logic [31:0] arm_v, fast_v, win_v, len_v;
		logic [31:0] dly_v [NDLY];
		case (s)
			SET_LOW: begin
				arm_v = '0;
				fast_v = '0;
				win_v = '0;
				len_v = '0;
				foreach (dly_v[i]) dly_v[i] = '0;
			end
			SET_HIGH: begin
				arm_v = '1;
				fast_v = '1;
				win_v = '1;
				len_v = '1;
				foreach (dly_v[i]) dly_v[i] = '1;
			end
			SET_WILD: begin
				arm_v = $urandom;
				fast_v = $urandom;
				win_v = $urandom;
				len_v = $urandom;
				foreach (dly_v[i]) dly_v[i] = $urandom;
			end
			default: begin
				arm_v = $urandom_range(500, 8000);
				fast_v = $urandom_range(1000, 20000);
				win_v = $urandom_range(5000, 80000);
				len_v = $urandom_range(0, 7);
				foreach (dly_v[i]) dly_v[i] = $urandom_range(0, 6000);
			end
		endcase
		write_reg(rsb_pkg::CFG_ARM_WAIT, arm_v);
		write_reg(rsb_pkg::CFG_FAST_FAIL, fast_v);
		write_reg(rsb_pkg::CFG_FAIL_WINDOW, win_v);
		write_reg(rsb_pkg::CFG_SCHED_LEN, len_v);
		write_reg(rsb_pkg::CFG_BACKOFF_DELAY_0, dly_v[0]);
		write_reg(rsb_pkg::CFG_BACKOFF_DELAY_1, dly_v[1]);
		write_reg(rsb_pkg::CFG_BACKOFF_DELAY_2, dly_v[2]);
		write_reg(rsb_pkg::CFG_BACKOFF_DELAY_3, dly_v[3]);
		// An index past the last register must not disturb any of them.
		if (s == SET_WILD)
			write_reg(rsb_pkg::CFG_BACKOFF_DELAY_3 + IDX_W'($urandom_range(1, 8)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every expected result is out and the pipeline is empty.
	task automatic wait_for_results();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One full lifecycle under reset values, plus the corner cases of time and counting.
	task automatic test_directed_lifecycle();
		rsb_pkg::item_t odd;
		odd = '1;
		send_event(odd);
		odd = '0;
		send_event(odd);
		send_event(tick_at(1'b1, 1'b1, 1'b0, 1'b1, 48'd100));
		send_event(tick_at(1'b1, 1'b1, 1'b1, 1'b1, 48'd200));
		send_event(spawned(32'sh7FFF_FFFF));
		send_event(exited(32'sd1, 32'd5, 1'b1, 48'd300));
		send_event(tick_at(1'b0, 1'b0, 1'b0, 1'b1, 48'd1299));
		send_event(tick_at(1'b0, 1'b0, 1'b0, 1'b1, 48'd1300));
		send_event(spawned(32'sh8000_0000));
		send_event(exited(-32'sd1, 32'd0, 1'b1, 48'd1400));
		// Spawn report while backing off, then fast failures until the block locks.
		send_event(spawned(32'sd5));
		send_event(exited(32'sd2, 32'd9999, 1'b1, 48'd1500));
		send_event(exited(32'sd2, 32'd0, 1'b1, 48'd1600));
		send_event(exited(32'sd2, 32'd0, 1'b1, 48'd1700));
		send_event(exited(32'sd2, 32'd0, 1'b1, 48'd1800));
		send_event(exited(32'sd2, 32'd0, 1'b1, 48'd1900));
		send_event(exited(32'sd2, 32'd0, 1'b1, 48'd2000));
		send_event(tick_at(1'b0, 1'b0, 1'b0, 1'b1, 48'd2100));
		// Re-arm from locked near the top of time so the deadline saturates.
		send_event(tick_at(1'b1, 1'b1, 1'b0, 1'b1, rsb_pkg::TIME_MAX - 48'd10));
		send_event(tick_at(1'b1, 1'b1, 1'b0, 1'b1, rsb_pkg::TIME_MAX - 48'd5));
		send_event(tick_at(1'b1, 1'b1, 1'b1, 1'b1, rsb_pkg::TIME_MAX));
		send_event(spawned(32'sd42));
		send_event(tick_at(1'b0, 1'b0, 1'b0, 1'b0, rsb_pkg::TIME_MAX));
		send_event(exited(32'sd3, 32'hFFFF_FFFF, 1'b1, rsb_pkg::TIME_MAX - 48'd100));
		// Timestamp wraps around: the window age is taken modulo the time width.
		send_event(exited(32'sd7, 32'd0, 1'b1, 48'd50));
		send_event(tick_at(1'b0, 1'b0, 1'b0, 1'b0, 48'd60));
		send_event(exited(32'sd0, 32'd0, 1'b1, 48'd70));
		item_valid <= 1'b0;
	endtask

	task automatic test_random_lifecycle(input setting_t s, input int count);
		wait_for_results();
		apply_setting(s);
		repeat (count) send_event(next_lifecycle_event());
		item_valid <= 1'b0;
	endtask

	// Result side: random stalls, and each result checked against the oldest expectation.
	always @(posedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		rsb_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("unexpected result item: mode=%0d worker=%0d",
						result.mode, result.current_worker);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.start_worker !== want.start_worker ||
						result.stop_worker !== want.stop_worker ||
						result.mode !== want.mode ||
						result.attempt_count !== want.attempt_count ||
						result.active_backoff !== want.active_backoff ||
						result.current_worker !== want.current_worker) begin
					if (fail_count < MAX_REPORTS)
						$display("mismatch: start %0d/%0d stop %0d/%0d mode %0d/%0d",
							want.start_worker, result.start_worker,
							want.stop_worker, result.stop_worker,
							want.mode, result.mode,
							" attempts %0d/%0d backoff %0d/%0d worker %0d/%0d",
							want.attempt_count, result.attempt_count,
							want.active_backoff, result.active_backoff,
							want.current_worker, result.current_worker);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		tx_idle_pct = 22;
		rx_idle_pct = 47;
		reset_prediction();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_lifecycle();
		test_random_lifecycle(SET_MODERATE, 320);
		test_random_lifecycle(SET_LOW, 320);
		tx_idle_pct = 47;
		rx_idle_pct = 22;
		test_random_lifecycle(SET_HIGH, 320);
		test_random_lifecycle(SET_WILD, 320);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_lifecycle(SET_MODERATE, 330);
		test_random_lifecycle(SET_WILD, 330);

		wait_for_results();
		fail_count += expected_results.size();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
